FILE: hdl/gwpe_pkg.sv
// Package for the grain window phase and envelope block.
// Holds the fixed-point widths, register codes, reset values and payload types.
// Has no dependencies.
package gwpe_pkg;

   // Fixed-point format and sample address width.
   localparam int FRAC_BITS = 16;
   localparam int ADDR_BITS = 20;

   // Field and state widths.
   localparam int PHASE_W       = 40;
   localparam int POS_W         = 38;
   localparam int START_EXTRA_W = 37;
   localparam int PITCH_W       = 24;
   localparam int RATE_W        = 24;
   localparam int RPM_W         = 23;
   localparam int DRAW_W        = 16;
   localparam int Q_W           = FRAC_BITS + 1;
   localparam int OFFSET_W      = ADDR_BITS + 1;
   localparam int OFFQ_W        = OFFSET_W + FRAC_BITS;
   localparam int WLEN_W        = ADDR_BITS + FRAC_BITS;
   localparam int NORM_W        = PHASE_W + 2;
   localparam int MUL_B_W       = (RPM_W > ADDR_BITS) ? RPM_W : ADDR_BITS;
   localparam int MUL_W         = DRAW_W + MUL_B_W;
   localparam int CNT_W         = $clog2(FRAC_BITS);

   // Configuration port.
   localparam int CSR_DATA_W  = 24;
   localparam int CSR_INDEX_W = 3;

   localparam logic [CSR_INDEX_W-1:0] REG_WINDOW_LENGTH     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_START_INDEX       = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_READ_OFFSET       = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_PLAYBACK_RATE     = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_RANDOM_PITCH_MAX  = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_RANDOM_START_SPAN = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_ATTACK_END        = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] REG_DECAY_START       = 3'd7;

   // Unity in the progress and gain formats.
   localparam logic [Q_W-1:0] ONE_Q = Q_W'(1) << FRAC_BITS;

   // Register values after reset.
   localparam logic [ADDR_BITS-1:0] WINDOW_LENGTH_RST = ADDR_BITS'(19200);
   localparam logic [RATE_W-1:0]    PLAYBACK_RATE_RST = RATE_W'(65536);
   localparam logic [Q_W-1:0]       ATTACK_END_RST    = Q_W'(9830);
   localparam logic [Q_W-1:0]       DECAY_START_RST   = Q_W'(55706);

   typedef struct packed {
      logic [DRAW_W-1:0] pitch_draw;
      logic [DRAW_W-1:0] start_draw;
   } req_type;

   typedef struct packed {
      logic signed [POS_W-1:0] read_position;
      logic [Q_W-1:0]          gain;
      logic                    grain_restarted;
      logic [Q_W-1:0]          grain_progress;
   } rsp_type;

endpackage

FILE: hdl/grain_window_phase_envelope.sv
// Top level of the grain window phase and envelope block.
// Uses gwpe_pkg for widths, register codes and the payload types.
//
// Usage: each item on the req_ channel is one audio sample tick carrying a
// random pitch draw and a random start draw. For each item the block returns
// exactly one item on the rsp_ channel with the read position, the trapezoid
// envelope gain, the grain restart flag and the progress through the window.
// The block advances its phase, wraps it by one window length when the offset
// phase leaves the window, and then derives progress and gain.
// Both channels use valid and stall. The csr_ port writes the eight settings
// registers and must only be used while the block is idle.
// One shared restoring divide step unit computes progress when the grain does
// not wrap, and the gain ramp outside the hold region, one quotient bit per
// cycle. req_stall stays high from acceptance until the result is handed to
// the output register, so the block takes no new item before it is through
// with the last one.
// Reset restores the register defaults and clears the phase and grain state.
// A stalled result stays in the output register; the next item is still
// accepted and worked on, and it waits at the end until that register frees.
module grain_window_phase_envelope (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  gwpe_pkg::req_type                     req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output gwpe_pkg::rsp_type                     rsp_data,
   input  logic                                  csr_we,
   input  logic [gwpe_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [gwpe_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   localparam int F = gwpe_pkg::FRAC_BITS;

   // Sequencer state codes.
   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_ADV  = 4'd1;
   localparam logic [3:0] ST_NORM = 4'd2;
   localparam logic [3:0] ST_WRAP = 4'd3;
   localparam logic [3:0] ST_MULP = 4'd4;
   localparam logic [3:0] ST_MULS = 4'd5;
   localparam logic [3:0] ST_FDIV = 4'd6;
   localparam logic [3:0] ST_POS1 = 4'd7;
   localparam logic [3:0] ST_POS2 = 4'd8;
   localparam logic [3:0] ST_GSET = 4'd9;
   localparam logic [3:0] ST_GDIV = 4'd10;
   localparam logic [3:0] ST_DONE = 4'd11;

   // Settings registers.
   logic [gwpe_pkg::ADDR_BITS-1:0] wlen_reg_ff,   wlen_reg_in;
   logic [gwpe_pkg::ADDR_BITS-1:0] start_idx_ff,  start_idx_in;
   logic [gwpe_pkg::OFFSET_W-1:0]  offset_ff,     offset_in;
   logic [gwpe_pkg::RATE_W-1:0]    rate_ff,       rate_in;
   logic [gwpe_pkg::RPM_W-1:0]     pitch_max_ff,  pitch_max_in;
   logic [gwpe_pkg::ADDR_BITS-1:0] start_span_ff, start_span_in;
   logic [gwpe_pkg::Q_W-1:0]       attack_ff,     attack_in;
   logic [gwpe_pkg::Q_W-1:0]       decay_ff,      decay_in;

   // Architectural state carried between ticks.
   logic [gwpe_pkg::PHASE_W-1:0]       phase_ff,       phase_in;
   logic [gwpe_pkg::PITCH_W-1:0]       pitch_extra_ff, pitch_extra_in;
   logic [gwpe_pkg::START_EXTRA_W-1:0] start_extra_ff, start_extra_in;
   logic [gwpe_pkg::Q_W-1:0]           frac_ff,        frac_in;

   // Working registers of the sequencer.
   logic [3:0]                    state_ff, state_in;
   logic [gwpe_pkg::DRAW_W-1:0]   pdraw_ff, pdraw_in;
   logic [gwpe_pkg::DRAW_W-1:0]   sdraw_ff, sdraw_in;
   logic [gwpe_pkg::NORM_W-1:0]   base_ff,  base_in;
   logic [gwpe_pkg::PHASE_W-1:0]  ph_ff,    ph_in;
   logic [gwpe_pkg::NORM_W-1:0]   norm_ff,  norm_in;
   logic                          restart_ff, restart_in;
   logic [gwpe_pkg::PHASE_W-1:0]  pos_ff,   pos_in;
   logic                          decay_mode_ff, decay_mode_in;
   logic [gwpe_pkg::Q_W-1:0]      gain_ff,  gain_in;

   // Shared divide step unit.
   logic [gwpe_pkg::WLEN_W-1:0]   rem_ff, rem_in;
   logic [gwpe_pkg::WLEN_W-1:0]   div_ff, div_in;
   logic [F-1:0]                  quo_ff, quo_in;
   logic [gwpe_pkg::CNT_W-1:0]    cnt_ff, cnt_in;

   // Output register.
   logic              rsp_valid_ff, rsp_valid_in;
   gwpe_pkg::rsp_type rsp_data_ff,  rsp_data_in;

   // Combinational helpers.
   logic                          req_take;
   logic                          out_free;
   logic [gwpe_pkg::WLEN_W:0]     rem_shift;
   logic                          rem_ge;
   logic [gwpe_pkg::WLEN_W-1:0]   rem_step;
   logic [F-1:0]                  quo_step;
   logic                          div_last;
   logic [gwpe_pkg::WLEN_W-1:0]   wlen_q;
   logic [gwpe_pkg::OFFQ_W-1:0]   offset_q;
   logic [gwpe_pkg::RATE_W-1:0]   rate_word;
   logic [gwpe_pkg::PHASE_W-1:0]  rate_ext;
   logic [gwpe_pkg::DRAW_W-1:0]   mul_a;
   logic [gwpe_pkg::MUL_B_W-1:0]  mul_b;
   logic [gwpe_pkg::MUL_W-1:0]    mul_p;
   logic [gwpe_pkg::Q_W-1:0]      attack_clamp;
   logic [gwpe_pkg::Q_W-1:0]      decay_clamp;
   logic                          norm_neg;
   logic                          norm_over;

   assign req_take  = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // A zero window length behaves as one sample.
   assign wlen_q   = {((wlen_reg_ff == '0) ? gwpe_pkg::ADDR_BITS'(1) : wlen_reg_ff),
                      {F{1'b0}}};
   assign offset_q = {offset_ff, {F{1'b0}}};
   assign rate_word = rate_ff;
   assign rate_ext  = {{(gwpe_pkg::PHASE_W - gwpe_pkg::RATE_W){rate_word[gwpe_pkg::RATE_W-1]}},
                       rate_word};

   // The offset phase is compared against the window as a signed value.
   assign norm_neg  = norm_ff[gwpe_pkg::NORM_W-1];
   assign norm_over = !norm_neg &&
                      (norm_ff >= gwpe_pkg::NORM_W'(wlen_q));

   // Restoring division: the remainder always stays below the divisor.
   assign rem_shift = {rem_ff, 1'b0};
   assign rem_ge    = (rem_shift >= {1'b0, div_ff});
   assign rem_step  = rem_ge ? gwpe_pkg::WLEN_W'(rem_shift - {1'b0, div_ff})
                             : rem_shift[gwpe_pkg::WLEN_W-1:0];
   assign quo_step  = {quo_ff[F-2:0], rem_ge};
   assign div_last  = (cnt_ff == gwpe_pkg::CNT_W'(F - 1));

   // One multiplier serves both grain draws.
   assign mul_a = (state_ff == ST_MULP) ? pdraw_ff : sdraw_ff;
   assign mul_b = (state_ff == ST_MULP) ? gwpe_pkg::MUL_B_W'(pitch_max_ff)
                                        : gwpe_pkg::MUL_B_W'(start_span_ff);
   assign mul_p = gwpe_pkg::MUL_W'(mul_a) * gwpe_pkg::MUL_W'(mul_b);

   // Ramp points above one behave as one.
   assign attack_clamp = (attack_ff > gwpe_pkg::ONE_Q) ? gwpe_pkg::ONE_Q : attack_ff;
   assign decay_clamp  = (decay_ff  > gwpe_pkg::ONE_Q) ? gwpe_pkg::ONE_Q : decay_ff;

   // Settings write decoder.
   always_comb begin
      wlen_reg_in   = wlen_reg_ff;
      start_idx_in  = start_idx_ff;
      offset_in     = offset_ff;
      rate_in       = rate_ff;
      pitch_max_in  = pitch_max_ff;
      start_span_in = start_span_ff;
      attack_in     = attack_ff;
      decay_in      = decay_ff;
      if (csr_we) begin
         unique case (csr_index)
            gwpe_pkg::REG_WINDOW_LENGTH:
               wlen_reg_in = csr_wdata[gwpe_pkg::ADDR_BITS-1:0];
            gwpe_pkg::REG_START_INDEX:
               start_idx_in = csr_wdata[gwpe_pkg::ADDR_BITS-1:0];
            gwpe_pkg::REG_READ_OFFSET:
               offset_in = csr_wdata[gwpe_pkg::OFFSET_W-1:0];
            gwpe_pkg::REG_PLAYBACK_RATE:
               rate_in = csr_wdata[gwpe_pkg::RATE_W-1:0];
            gwpe_pkg::REG_RANDOM_PITCH_MAX:
               pitch_max_in = csr_wdata[gwpe_pkg::RPM_W-1:0];
            gwpe_pkg::REG_RANDOM_START_SPAN:
               start_span_in = csr_wdata[gwpe_pkg::ADDR_BITS-1:0];
            gwpe_pkg::REG_ATTACK_END:
               attack_in = csr_wdata[gwpe_pkg::Q_W-1:0];
            gwpe_pkg::REG_DECAY_START:
               decay_in = csr_wdata[gwpe_pkg::Q_W-1:0];
            default: ;
         endcase
      end
   end

   // Sequencer.
   always_comb begin
      state_in       = state_ff;
      pdraw_in       = pdraw_ff;
      sdraw_in       = sdraw_ff;
      base_in        = base_ff;
      ph_in          = ph_ff;
      norm_in        = norm_ff;
      restart_in     = restart_ff;
      pos_in         = pos_ff;
      decay_mode_in  = decay_mode_ff;
      gain_in        = gain_ff;
      rem_in         = rem_ff;
      div_in         = div_ff;
      quo_in         = quo_ff;
      cnt_in         = cnt_ff;
      phase_in       = phase_ff;
      pitch_extra_in = pitch_extra_ff;
      start_extra_in = start_extra_ff;
      frac_in        = frac_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_data_in    = rsp_data_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               pdraw_in = req_data.pitch_draw;
               sdraw_in = req_data.start_draw;
               // Window origin relative to the phase: read_offset - start_index.
               base_in  = gwpe_pkg::NORM_W'(
                  {{(gwpe_pkg::NORM_W - gwpe_pkg::OFFQ_W){offset_q[gwpe_pkg::OFFQ_W-1]}},
                   offset_q} - gwpe_pkg::NORM_W'({start_idx_ff, {F{1'b0}}}));
               state_in = ST_ADV;
            end
         end
         ST_ADV: begin
            ph_in    = gwpe_pkg::PHASE_W'(phase_ff + rate_ext
                                          + gwpe_pkg::PHASE_W'(pitch_extra_ff));
            state_in = ST_NORM;
         end
         ST_NORM: begin
            norm_in  = gwpe_pkg::NORM_W'(
                          {{(gwpe_pkg::NORM_W - gwpe_pkg::PHASE_W){ph_ff[gwpe_pkg::PHASE_W-1]}},
                           ph_ff} + base_ff);
            state_in = ST_WRAP;
         end
         ST_WRAP: begin
            // Set up the progress division; it is used only without a wrap.
            rem_in = norm_ff[gwpe_pkg::WLEN_W-1:0];
            div_in = wlen_q;
            quo_in = '0;
            cnt_in = '0;
            if (norm_over) begin
               ph_in      = gwpe_pkg::PHASE_W'(ph_ff - gwpe_pkg::PHASE_W'(wlen_q));
               restart_in = 1'b1;
               state_in   = ST_MULP;
            end else if (norm_neg) begin
               ph_in      = gwpe_pkg::PHASE_W'(ph_ff + gwpe_pkg::PHASE_W'(wlen_q));
               restart_in = 1'b1;
               state_in   = ST_MULP;
            end else begin
               restart_in = 1'b0;
               state_in   = ST_FDIV;
            end
         end
         ST_MULP: begin
            pitch_extra_in = gwpe_pkg::PITCH_W'(mul_p >> gwpe_pkg::DRAW_W);
            frac_in        = '0;
            state_in       = ST_MULS;
         end
         ST_MULS: begin
            start_extra_in = gwpe_pkg::START_EXTRA_W'({mul_p, {F{1'b0}}} >> gwpe_pkg::DRAW_W);
            state_in       = ST_POS1;
         end
         ST_FDIV: begin
            rem_in = rem_step;
            quo_in = quo_step;
            cnt_in = gwpe_pkg::CNT_W'(cnt_ff + 1'b1);
            if (div_last) begin
               frac_in  = gwpe_pkg::Q_W'(quo_step);
               state_in = ST_POS1;
            end
         end
         ST_POS1: begin
            phase_in = ph_ff;
            pos_in   = gwpe_pkg::PHASE_W'(ph_ff +
                          {{(gwpe_pkg::PHASE_W - gwpe_pkg::OFFQ_W){offset_q[gwpe_pkg::OFFQ_W-1]}},
                           offset_q});
            state_in = ST_POS2;
         end
         ST_POS2: begin
            pos_in   = gwpe_pkg::PHASE_W'(pos_ff + gwpe_pkg::PHASE_W'(start_extra_ff));
            state_in = ST_GSET;
         end
         ST_GSET: begin
            quo_in = '0;
            cnt_in = '0;
            if (frac_ff < attack_clamp) begin
               rem_in        = gwpe_pkg::WLEN_W'(frac_ff);
               div_in        = gwpe_pkg::WLEN_W'(attack_clamp);
               decay_mode_in = 1'b0;
               state_in      = ST_GDIV;
            end else if (frac_ff > decay_clamp) begin
               rem_in        = gwpe_pkg::WLEN_W'(frac_ff - decay_clamp);
               div_in        = gwpe_pkg::WLEN_W'(gwpe_pkg::ONE_Q - decay_clamp);
               decay_mode_in = 1'b1;
               state_in      = ST_GDIV;
            end else begin
               gain_in  = gwpe_pkg::ONE_Q;
               state_in = ST_DONE;
            end
         end
         ST_GDIV: begin
            rem_in = rem_step;
            quo_in = quo_step;
            cnt_in = gwpe_pkg::CNT_W'(cnt_ff + 1'b1);
            if (div_last) begin
               gain_in  = decay_mode_ff ? gwpe_pkg::Q_W'(gwpe_pkg::ONE_Q - gwpe_pkg::Q_W'(quo_step))
                                        : gwpe_pkg::Q_W'(quo_step);
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // Hand the item over once the output register is free.
            if (out_free) begin
               rsp_valid_in                = 1'b1;
               rsp_data_in.read_position   = pos_ff[gwpe_pkg::POS_W-1:0];
               rsp_data_in.gain            = gain_ff;
               rsp_data_in.grain_restarted = restart_ff;
               rsp_data_in.grain_progress  = frac_ff;
               state_in                    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control and architectural state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         rsp_valid_ff   <= 1'b0;
         wlen_reg_ff    <= gwpe_pkg::WINDOW_LENGTH_RST;
         start_idx_ff   <= '0;
         offset_ff      <= '0;
         rate_ff        <= gwpe_pkg::PLAYBACK_RATE_RST;
         pitch_max_ff   <= '0;
         start_span_ff  <= '0;
         attack_ff      <= gwpe_pkg::ATTACK_END_RST;
         decay_ff       <= gwpe_pkg::DECAY_START_RST;
         phase_ff       <= '0;
         pitch_extra_ff <= '0;
         start_extra_ff <= '0;
         frac_ff        <= '0;
      end else begin
         state_ff       <= state_in;
         rsp_valid_ff   <= rsp_valid_in;
         wlen_reg_ff    <= wlen_reg_in;
         start_idx_ff   <= start_idx_in;
         offset_ff      <= offset_in;
         rate_ff        <= rate_in;
         pitch_max_ff   <= pitch_max_in;
         start_span_ff  <= start_span_in;
         attack_ff      <= attack_in;
         decay_ff       <= decay_in;
         phase_ff       <= phase_in;
         pitch_extra_ff <= pitch_extra_in;
         start_extra_ff <= start_extra_in;
         frac_ff        <= frac_in;
      end
   end

   // Working and payload registers.
   always_ff @(posedge clock) begin
      pdraw_ff      <= pdraw_in;
      sdraw_ff      <= sdraw_in;
      base_ff       <= base_in;
      ph_ff         <= ph_in;
      norm_ff       <= norm_in;
      restart_ff    <= restart_in;
      pos_ff        <= pos_in;
      decay_mode_ff <= decay_mode_in;
      gain_ff       <= gain_in;
      rem_ff        <= rem_in;
      div_ff        <= div_in;
      quo_ff        <= quo_in;
      cnt_ff        <= cnt_in;
      rsp_data_ff   <= rsp_data_in;
   end

endmodule

FILE: hdl/gwpe_checker.sv
// Port-level checker for the grain window phase and envelope block.
// Uses gwpe_pkg for the payload types; bound to grain_window_phase_envelope below.
module gwpe_port_props (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input gwpe_pkg::rsp_type rsp_data
);

   // An accepted item keeps the block busy in the following cycle.
   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input accepted while block was not busy afterwards");

   // A result is not dropped while the receiver stalls.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("stalled result was withdrawn");

   // A new result only appears at the end of an item's work.
   a_rsp_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result appeared without an item in progress");

   // The envelope never exceeds unity.
   a_gain_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.gain <= gwpe_pkg::ONE_Q)
      else $error("gain above one");

   // A restarted grain begins at zero progress.
   a_restart_progress: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.grain_restarted |-> rsp_data.grain_progress == '0)
      else $error("grain restart with nonzero progress");

endmodule

bind grain_window_phase_envelope gwpe_port_props u_gwpe_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
